FILE: hdl/fapa_pkg.sv
// Shared codes, widths and limits of the adjacent-pair arbiter.
`timescale 1ns / 1ps

package fapa_pkg;

    // Fixed field widths
    localparam int WHO_W    = 4;
    localparam int CFG_W    = 5;
    localparam int ERR_W    = 2;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 8;

    // Size after reset
    localparam logic [CFG_W-1:0] RESET_SIZE = 5'd16;

    // Grants handed out per event at most
    localparam int MAX_GRANTS = 8;
    localparam int GRANT_W    = $clog2(MAX_GRANTS + 1);

    // Operation codes
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_DUP     = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NO_HOLD = 2'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_IDX = 2'd3;

    // One result on its way to the output register
    typedef struct packed {
        logic             granted;
        logic [WHO_W-1:0] grantee;
        logic             last;
        logic [ERR_W-1:0] error;
    } result_t;

endpackage

FILE: hdl/fifo_fair_adjacent_pair_arbiter.sv
// Top level: FIFO-fair arbiter for a ring of requesters sharing adjacent resource pairs.
`timescale 1ns / 1ps

// Requester i needs resources i and i+1 (mod N). A request (tuser 0) queues the
// requester; a release (tuser 1) frees its pair. After each valid event the queue
// head is granted as long as its pair is free, up to MAX_GRANTS per event, strictly
// first come, first served. Every event returns one or more results on the master
// side, tlast on the final one; a rejected event returns a single result with an
// error code. One event is handled at a time, and the master side can stall it;
// the pace is set by the single read port of the wait ring and the one eligibility
// check per queue head. A write to cfg_wdata sets the ring size (clamped to
// 2..MAX_REQUESTERS) and empties the queue and frees every resource.
module fifo_fair_adjacent_pair_arbiter #(
    parameter int MAX_REQUESTERS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_we,
    input  logic [fapa_pkg::CFG_W-1:0]    cfg_wdata,      // num_requesters
    // event requests
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fapa_pkg::S_DATA_W-1:0] s_tdata,        // [3:0] requester
    input  logic                          s_tuser,        // operation
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fapa_pkg::M_DATA_W-1:0] m_tdata,        // [3:0] grantee, [5:4] error
    output logic                          m_tuser,        // granted
    output logic                          m_tlast
);
    import fapa_pkg::*;

    localparam int MW = MAX_REQUESTERS;
    localparam int IW = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;
    localparam int NW = $clog2(MAX_REQUESTERS + 1);
    localparam int CW = (NW > CFG_W) ? NW : CFG_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_EVAL  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [CFG_W-1:0]   num_reg, num_next;
    logic [IW-1:0]      ring_head_reg, ring_head_next;
    logic [NW-1:0]      ring_count_reg, ring_count_next;
    logic [MW-1:0]      busy_reg, busy_next;
    logic [MW-1:0]      holding_reg, holding_next;
    logic [MW-1:0]      queued_reg, queued_next;
    logic               op_reg, op_next;
    logic [WHO_W-1:0]   who_reg, who_next;
    logic [GRANT_W-1:0] grants_reg, grants_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [WHO_W-1:0]   pend_who_reg, pend_who_next;
    logic               m_valid_reg, m_valid_next;
    result_t            m_res_reg, m_res_next;

    // wait ring storage
    logic [WHO_W-1:0]   wait_ring [MAX_REQUESTERS];
    logic [WHO_W-1:0]   rd_reg;
    logic               wr_en;
    logic [IW-1:0]      wr_ix;

    logic [NW-1:0]      n_size;
    logic               out_free;
    logic [IW-1:0]      who_ix, head_ix;
    logic [MW-1:0]      who_pair, head_pair, who_bit, head_bit;
    logic [NW:0]        tail_sum;
    logic               bad_idx, can_grant;

    // Mask of the two resources of a requester
    function automatic logic [MW-1:0] pair_mask(input logic [IW-1:0] ix,
                                                input logic [NW-1:0] n);
        logic [NW-1:0] nxt;
        logic [IW-1:0] nxt_ix;
        nxt    = NW'(ix) + NW'(1);
        nxt_ix = (nxt == n) ? IW'(0) : IW'(nxt);
        return (MW'(1) << ix) | (MW'(1) << nxt_ix);
    endfunction

    // Effective ring size
    always_comb begin
        if (CW'(num_reg) < CW'(2)) begin
            n_size = NW'(2);
        end else if (CW'(num_reg) > CW'(MAX_REQUESTERS)) begin
            n_size = NW'(MAX_REQUESTERS);
        end else begin
            n_size = NW'(num_reg);
        end
    end

    assign out_free  = !m_valid_reg || m_tready;
    assign who_ix    = IW'(who_reg);
    assign head_ix   = IW'(rd_reg);
    assign who_pair  = pair_mask(who_ix, n_size);
    assign head_pair = pair_mask(head_ix, n_size);
    assign who_bit   = MW'(1) << who_ix;
    assign head_bit  = MW'(1) << head_ix;
    assign bad_idx   = CW'(who_reg) >= CW'(n_size);
    assign can_grant = (ring_count_reg != '0) && (grants_reg != GRANT_W'(MAX_GRANTS))
                       && ((busy_reg & head_pair) == '0);

    // Tail slot: head + count, wrapped once at the ring size
    always_comb begin
        tail_sum = (NW+1)'(ring_head_reg) + (NW+1)'(ring_count_reg);
        if (tail_sum >= (NW+1)'(n_size)) begin
            tail_sum = tail_sum - (NW+1)'(n_size);
        end
        wr_ix = IW'(tail_sum);
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        num_next        = num_reg;
        ring_head_next  = ring_head_reg;
        ring_count_next = ring_count_reg;
        busy_next       = busy_reg;
        holding_next    = holding_reg;
        queued_next     = queued_reg;
        op_next         = op_reg;
        who_next        = who_reg;
        grants_next     = grants_reg;
        pend_valid_next = pend_valid_reg;
        pend_who_next   = pend_who_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_res_next      = m_res_reg;
        wr_en           = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    op_next         = s_tuser;
                    who_next        = s_tdata[WHO_W-1:0];
                    grants_next     = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // validate and apply the event
                if (bad_idx) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_res_next   = '{1'b0, '0, 1'b1, ERR_BAD_IDX};
                        state_next   = ST_IDLE;
                    end
                end else if (op_reg == OP_REQUEST) begin
                    if ((((queued_reg | holding_reg) & who_bit) != '0)
                        || (ring_count_reg >= n_size)) begin
                        if (out_free) begin
                            m_valid_next = 1'b1;
                            m_res_next   = '{1'b0, '0, 1'b1, ERR_DUP};
                            state_next   = ST_IDLE;
                        end
                    end else begin
                        wr_en           = 1'b1;
                        ring_count_next = ring_count_reg + NW'(1);
                        queued_next     = queued_reg | who_bit;
                        state_next      = ST_READ;
                    end
                end else begin
                    if ((holding_reg & who_bit) == '0) begin
                        if (out_free) begin
                            m_valid_next = 1'b1;
                            m_res_next   = '{1'b0, '0, 1'b1, ERR_NO_HOLD};
                            state_next   = ST_IDLE;
                        end
                    end else begin
                        holding_next = holding_reg & ~who_bit;
                        busy_next    = busy_reg & ~who_pair;
                        state_next   = ST_READ;
                    end
                end
            end
            ST_READ: begin
                // ring read of the current head settles
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (can_grant) begin
                    // previous grant goes out first, known not to be the last
                    if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_res_next   = '{1'b1, pend_who_reg, 1'b0, ERR_OK};
                        end
                        busy_next       = busy_reg | head_pair;
                        holding_next    = holding_reg | head_bit;
                        queued_next     = queued_reg & ~head_bit;
                        ring_head_next  = (NW'(ring_head_reg) + NW'(1) == n_size) ?
                                          '0 : ring_head_reg + IW'(1);
                        ring_count_next = ring_count_reg - NW'(1);
                        grants_next     = grants_reg + GRANT_W'(1);
                        pend_valid_next = 1'b1;
                        pend_who_next   = rd_reg;
                        state_next      = ST_READ;
                    end
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    if (pend_valid_reg) begin
                        m_res_next = '{1'b1, pend_who_reg, 1'b1, ERR_OK};
                    end else begin
                        m_res_next = '{1'b0, '0, 1'b1, ERR_OK};
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // size change empties the ring
        if (cfg_we) begin
            num_next        = cfg_wdata;
            ring_head_next  = '0;
            ring_count_next = '0;
            busy_next       = '0;
            holding_next    = '0;
            queued_next     = '0;
            pend_valid_next = 1'b0;
            state_next      = ST_IDLE;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            num_reg        <= RESET_SIZE;
            ring_head_reg  <= '0;
            ring_count_reg <= '0;
            busy_reg       <= '0;
            holding_reg    <= '0;
            queued_reg     <= '0;
            grants_reg     <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            num_reg        <= num_next;
            ring_head_reg  <= ring_head_next;
            ring_count_reg <= ring_count_next;
            busy_reg       <= busy_next;
            holding_reg    <= holding_next;
            queued_reg     <= queued_next;
            grants_reg     <= grants_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        who_reg      <= who_next;
        pend_who_reg <= pend_who_next;
        m_res_reg    <= m_res_next;
    end

    // Wait ring: one write port, registered read of the head slot
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            wait_ring[wr_ix] <= who_reg;
        end
        rd_reg <= wait_ring[ring_head_reg];
    end

    assign s_tready = (state_reg == ST_IDLE) && aresetn;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.granted;
    assign m_tlast  = m_res_reg.last;
    assign m_tdata  = {{(M_DATA_W - WHO_W - ERR_W){1'b0}}, m_res_reg.error,
                       m_res_reg.grantee};

endmodule

FILE: hdl/fapa_checker.sv
// Port-level checks of the adjacent-pair arbiter, bound to the top level.
`timescale 1ns / 1ps

module fapa_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          cfg_we,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fapa_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          m_tuser,
    input logic                          m_tlast
);
    import fapa_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("stalled result changed");

    // a result without a grant always closes its event
    a_nogrant_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("no-grant result not marked last");

    // an error never comes with a grant or a grantee
    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[5:4] != ERR_OK) |-> !m_tuser && (m_tdata[3:0] == 4'd0))
        else $error("error result carries a grant");

    // one event at a time; a size write returns the block to idle
    a_one_event: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !cfg_we |=> !s_tready)
        else $error("request accepted while busy");

endmodule

bind fifo_fair_adjacent_pair_arbiter fapa_checker u_fapa_checker (.*);
